// ----- hw/rtl/lsdrs_pkg.sv -----
// Shared types and constants for the LSD decimal radix sorter.
`timescale 1ns / 1ps

package lsdrs_pkg;

  // Element and digit widths
  localparam int VAL_W   = 31;
  localparam int DIGIT_W = 4;
  localparam int RADIX   = 10;

  // Pass limit: every 31-bit value is below ten to the tenth
  localparam logic [DIGIT_W-1:0] MAX_PASSES      = 4'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_COUNT_RST = 4'd10;

  // Default capacity
  localparam int MAX_ITEMS_DEF = 64;

  // Register port
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_DIGIT_COUNT = 1'b0;

  // Reciprocal of ten: floor(q * RECIP_10 / 2^RECIP_SHIFT) == q / 10 for q < 2^32
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = VAL_W + 32;

  // Request carried on the input channel
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last_item;
  } item_t;

  // Request carried on the output channel
  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             last_result;
  } result_t;

  // Stored element: original value and its remaining quotient for later digits
  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] quo;
  } elem_t;

endpackage

// ----- hw/rtl/lsdrs_digit.sv -----
// Digit unit: splits a quotient into its lowest decimal digit and the rest.
`timescale 1ns / 1ps

module lsdrs_digit (
  input  logic                             clk,
  input  lsdrs_pkg::elem_t                 din,
  output lsdrs_pkg::elem_t                 dout,
  output logic [lsdrs_pkg::DIGIT_W-1:0]    digit
);
  import lsdrs_pkg::*;

  localparam int Q10_W = PROD_W - RECIP_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  quo_r;
  logic [Q10_W-1:0]  q10;
  logic [VAL_W-1:0]  q10_x;
  logic [VAL_W-1:0]  rem;

  // Reciprocal multiply, registered
  always_ff @(posedge clk) begin
    prod  <= {{(PROD_W-VAL_W){1'b0}}, din.quo} * {{(PROD_W-32){1'b0}}, RECIP_10};
    val_r <= din.val;
    quo_r <= din.quo;
  end

  // Quotient by ten and remainder
  always_comb begin
    q10   = prod[PROD_W-1:RECIP_SHIFT];
    q10_x = VAL_W'(q10);
    rem   = quo_r - ((q10_x << 3) + (q10_x << 1));
    digit = rem[DIGIT_W-1:0];
    dout.val = val_r;
    dout.quo = q10_x;
  end

endmodule

// ----- hw/rtl/lsd_decimal_radix_sort.sv -----
// LSD decimal radix sorter: top level with sequencer, element memories and register port.
`timescale 1ns / 1ps

// Items are loaded at one per cycle until the one marked last_item; items beyond
// MAX_ITEMS are dropped. The block then runs min(digit_count, 10) stable decimal
// passes over the n stored items and emits them in sorted order, last_result on the
// final one. Each pass is a counting sweep, a prefix step over the ten buckets and a
// scatter sweep, all fed by the one digit unit and a single read port per element
// memory; emitting passes through a read state and a load state for each result.
// No request is taken while a run is under way.
// The last result may wait on the output while loading of the next set starts.
module lsd_decimal_radix_sort #(
  parameter int MAX_ITEMS = lsdrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  lsdrs_pkg::item_t                 item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output lsdrs_pkg::result_t               result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsdrs_pkg::ADDR_W-1:0]     paddr,
  input  logic [lsdrs_pkg::DATA_W-1:0]     pwdata,
  output logic [lsdrs_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);
  import lsdrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CNT, S_PFX, S_SCT, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   item_count;
  logic [CNT_W-1:0]   rd_idx;
  logic               v1;
  logic               v2;
  logic               src;
  logic [DIGIT_W-1:0] pass_index;
  logic [DIGIT_W-1:0] npass;
  logic [DIGIT_W-1:0] pfx_idx;
  logic [CNT_W-1:0]   run;
  logic [CNT_W-1:0]   bucket [RADIX];
  logic [DIGIT_W-1:0] digit_count;

  // Element memories, used ping-pong between passes
  elem_t              mem_a [MAX_ITEMS];
  elem_t              mem_b [MAX_ITEMS];
  elem_t              rd_a;
  elem_t              rd_b;
  elem_t              rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  elem_t              wr_data;
  logic               we_a;
  logic               we_b;

  elem_t              du_out;
  logic [DIGIT_W-1:0] du_digit;

  logic               issue;
  logic               sweep_done;
  logic               load_wr;
  logic               sct_wr;
  logic               emit_last;
  logic               cfg_wr;
  logic [ADDR_W-3:0]  cfg_idx;
  logic [DIGIT_W-1:0] pass_sat;

  // Register port decode
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == REG_DIGIT_COUNT);
  assign prdata  = (cfg_idx == REG_DIGIT_COUNT) ? DATA_W'(digit_count) : '0;

  // Sweep and write control
  always_comb begin
    item_ready = (state == S_IDLE);
    issue      = ((state == S_CNT) || (state == S_SCT)) && (rd_idx < item_count);
    sweep_done = !issue && !v1 && !v2;
    load_wr    = item_valid && item_ready && (item_count < CNT_W'(MAX_ITEMS));
    sct_wr     = (state == S_SCT) && v2;
    emit_last  = (rd_idx + CNT_W'(1)) == item_count;
    pass_sat   = (digit_count > MAX_PASSES) ? MAX_PASSES : digit_count;
    rd_addr    = rd_idx[IDX_W-1:0];
    rd_data    = src ? rd_b : rd_a;
    if (load_wr) begin
      wr_addr     = item_count[IDX_W-1:0];
      wr_data.val = item.value;
      wr_data.quo = item.value;
    end else begin
      wr_addr = bucket[du_digit][IDX_W-1:0];
      wr_data = du_out;
    end
    we_a = load_wr || (sct_wr && src);
    we_b = sct_wr && !src;
  end

  // Memory A
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[rd_addr];
  end

  // Memory B
  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b <= mem_b[rd_addr];
  end

  // Shared digit unit
  lsdrs_digit u_digit (
    .clk   (clk),
    .din   (rd_data),
    .dout  (du_out),
    .digit (du_digit)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      item_count   <= '0;
      rd_idx       <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      src          <= 1'b0;
      pass_index   <= '0;
      npass        <= '0;
      pfx_idx      <= '0;
      run          <= '0;
      digit_count  <= DIGIT_COUNT_RST;
      result_valid <= 1'b0;
      for (int i = 0; i < RADIX; i++) begin
        bucket[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        digit_count <= pwdata[DIGIT_W-1:0];
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      v1 <= issue;
      v2 <= v1;
      if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      // count or claim a bucket slot
      if (v2) begin
        bucket[du_digit] <= bucket[du_digit] + CNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (load_wr) begin
              item_count <= item_count + CNT_W'(1);
            end
            if (item.last_item) begin
              npass      <= pass_sat;
              pass_index <= '0;
              src        <= 1'b0;
              rd_idx     <= '0;
              if (pass_sat == '0) begin
                state <= S_EMIT_RD;
              end else begin
                state <= S_CNT;
                for (int i = 0; i < RADIX; i++) begin
                  bucket[i] <= '0;
                end
              end
            end
          end
        end
        S_CNT: begin
          if (sweep_done) begin
            pfx_idx <= '0;
            run     <= '0;
            state   <= S_PFX;
          end
        end
        S_PFX: begin
          // counts become start offsets
          bucket[pfx_idx] <= run;
          run             <= run + bucket[pfx_idx];
          if (pfx_idx == DIGIT_W'(RADIX - 1)) begin
            rd_idx <= '0;
            state  <= S_SCT;
          end else begin
            pfx_idx <= pfx_idx + DIGIT_W'(1);
          end
        end
        S_SCT: begin
          if (sweep_done) begin
            src    <= !src;
            rd_idx <= '0;
            if (pass_index + DIGIT_W'(1) == npass) begin
              state <= S_EMIT_RD;
            end else begin
              pass_index <= pass_index + DIGIT_W'(1);
              state      <= S_CNT;
              for (int i = 0; i < RADIX; i++) begin
                bucket[i] <= '0;
              end
            end
          end
        end
        S_EMIT_RD: begin
          if (!result_valid) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          result.sorted_value <= rd_data.val;
          result.last_result  <= emit_last;
          result_valid        <= 1'b1;
          if (emit_last) begin
            state      <= S_IDLE;
            item_count <= '0;
            pass_index <= '0;
            src        <= 1'b0;
            rd_idx     <= '0;
          end else begin
            rd_idx <= rd_idx + CNT_W'(1);
            state  <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ((state == S_CNT) || (state == S_SCT)))
    else $error("digit pipeline busy outside a sweep");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (du_digit < DIGIT_W'(RADIX)))
    else $error("digit out of range");

  a_scatter_slot: assert property (@(posedge clk) disable iff (rst)
    sct_wr |-> (bucket[du_digit] < item_count))
    else $error("scatter slot beyond stored items");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT_LD) && emit_last) |=>
      ((state == S_IDLE) && (item_count == '0) && result_valid && result.last_result))
    else $error("run did not close after final result");

endmodule
